// ===== hdl/fcr_pkg.sv =====
// shared types, register indexes and tap helper for the clamped ring fir filter
package fcr_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned PROD_W  = 2 * DATA_W;
   localparam int unsigned ACC_W   = PROD_W + 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned COEF_NUM  = 4;
   localparam int unsigned COEF_SEL_W = 2;
   localparam int unsigned ROUND_SHIFT = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OUTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_THIRD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER = 3'd5;

   localparam logic signed [DATA_W-1:0] COEF_CENTER_RESET = 16'sd32767;

   typedef struct packed {
      logic                  load;
      logic                  mul;
      logic                  acc;
      logic                  emit;
      logic [COEF_SEL_W-1:0] coef_sel;
   } fcr_cmd_type;

   typedef struct packed {
      logic out_free;
   } fcr_status_type;

   // coefficient number for a tap: distance to the nearer end, capped at the center one
   function automatic logic [COEF_SEL_W-1:0] fcr_coef_sel(input int unsigned tap,
                                                           input int unsigned order);
      int unsigned mirror;
      int unsigned k;
      mirror = order - tap;
      k = (tap < mirror) ? tap : mirror;
      if (k > COEF_NUM - 1) begin
         k = COEF_NUM - 1;
      end
      return k[COEF_SEL_W-1:0];
   endfunction

endpackage

// ===== hdl/fcr_ctrl.sv =====
// sequencer: load, one multiply per tap, final add, then hand the word to the output
module fcr_ctrl #(
   parameter int unsigned FILTER_ORDER = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fcr_pkg::fcr_status_type status,
   output fcr_pkg::fcr_cmd_type   cmd
);
   import fcr_pkg::*;

   localparam int unsigned RING_LEN = FILTER_ORDER + 1;
   localparam int unsigned SLOT_W   = $clog2(RING_LEN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] tap_ff, tap_in;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      cmd          = '0;
      cmd.coef_sel = fcr_coef_sel(32'(tap_ff), FILTER_ORDER);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               tap_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mul = 1'b1;
            cmd.acc = (tap_ff != '0);
            if (tap_ff == SLOT_W'(FILTER_ORDER)) begin
               state_in = ST_ADD;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_ADD: begin
            cmd.acc  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

// ===== hdl/fcr_datapath.sv =====
// registers, clamp, sample ring, shared multiply-accumulate and rounding output stage
module fcr_datapath #(
   parameter int unsigned FILTER_ORDER = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fcr_pkg::fcr_cmd_type                   cmd,
   output fcr_pkg::fcr_status_type                status,
   input  logic signed [fcr_pkg::DATA_W-1:0]      req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fcr_pkg::DATA_W-1:0]      rsp_filtered,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fcr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fcr_pkg::DATA_W-1:0]             csr_data
);
   import fcr_pkg::*;

   localparam int unsigned RING_LEN = FILTER_ORDER + 1;
   localparam int unsigned SLOT_W   = $clog2(RING_LEN);

   logic signed [DATA_W-1:0] clamp_low_ff;
   logic signed [DATA_W-1:0] clamp_high_ff;
   logic signed [DATA_W-1:0] coef_ff [COEF_NUM];

   logic signed [DATA_W-1:0] ring_ff [RING_LEN];
   logic [SLOT_W-1:0]        write_slot_ff;
   logic [SLOT_W-1:0]        read_slot_ff;
   logic [SLOT_W-1:0]        write_slot_in;
   logic [SLOT_W-1:0]        read_slot_in;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_filtered_ff;

   logic signed [DATA_W-1:0] clamped;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [DATA_W-1:0] saturated;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_low_ff  <= '0;
         clamp_high_ff <= '0;
         coef_ff[0]    <= '0;
         coef_ff[1]    <= '0;
         coef_ff[2]    <= '0;
         coef_ff[3]    <= COEF_CENTER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CLAMP_LOW:   clamp_low_ff  <= csr_data;
            CSR_CLAMP_HIGH:  clamp_high_ff <= csr_data;
            CSR_COEF_OUTER:  coef_ff[0]    <= csr_data;
            CSR_COEF_SECOND: coef_ff[1]    <= csr_data;
            CSR_COEF_THIRD:  coef_ff[2]    <= csr_data;
            CSR_COEF_CENTER: coef_ff[3]    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // inverted bounds: the low test wins
   always_comb begin
      clamped = req_sample;
      if ((clamp_low_ff != '0) || (clamp_high_ff != '0)) begin
         if (req_sample < clamp_low_ff) begin
            clamped = clamp_low_ff;
         end else if (req_sample > clamp_high_ff) begin
            clamped = clamp_high_ff;
         end
      end
   end

   assign write_slot_in = (write_slot_ff == SLOT_W'(RING_LEN - 1)) ? '0
                                                                  : write_slot_ff + 1'b1;
   assign read_slot_in  = (read_slot_ff == SLOT_W'(RING_LEN - 1)) ? '0
                                                                 : read_slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_LEN; i++) begin
            ring_ff[i] <= '0;
         end
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
      end else if (cmd.load) begin
         ring_ff[write_slot_ff] <= clamped;
         write_slot_ff          <= write_slot_in;
         read_slot_ff           <= write_slot_in;
      end else if (cmd.mul) begin
         read_slot_ff <= read_slot_in;
      end
   end

   // oldest sample meets tap 0
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= coef_ff[cmd.coef_sel] * ring_ff[read_slot_ff];
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, shift down, saturate
   always_comb begin
      rounded = (acc_ff + ACC_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (rounded > ACC_W'(32767)) begin
         saturated = 16'sh7fff;
      end else if (rounded < -ACC_W'(32768)) begin
         saturated = 16'sh8000;
      end else begin
         saturated = rounded[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_filtered_ff <= saturated;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered    = rsp_filtered_ff;

endmodule

// ===== hdl/fir_filter_clamped_ring_top.sv =====
// top level of the clamped ring fir filter
// Symmetric FIR filter of order FILTER_ORDER over a ring of the latest samples.
// Each accepted sample is optionally clamped, stored, and filtered with one
// shared 16x16 multiplier: a load step, one multiply per tap, a step to finish
// the accumulation and a step to round into the output register, which waits
// until that register is free. req_stall stays high from acceptance until
// the result has been moved into the output register, which then holds it for
// the receiver while the next word is taken. Registers are written by index on
// the csr port (0 clamp_low, 1 clamp_high, 2..5 coefficients outer to center,
// Q1.15); the port is always ready and higher indexes are ignored.
module fir_filter_clamped_ring_top #(
   parameter int unsigned FILTER_ORDER = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fcr_pkg::DATA_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [fcr_pkg::DATA_W-1:0] rsp_filtered,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fcr_pkg::DATA_W-1:0]        csr_data
);
   import fcr_pkg::*;

   fcr_cmd_type    cmd;
   fcr_status_type status;

   fcr_ctrl #(
      .FILTER_ORDER(FILTER_ORDER)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   fcr_datapath #(
      .FILTER_ORDER(FILTER_ORDER)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_filtered(rsp_filtered),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule
